// File: src/sspg_pkg.sv
// shared types, constants and helpers of the stepper segment profile generator
package sspg_pkg;

  localparam int SEG_COUNT = 6;
  localparam int CFG_COUNT = 8;
  localparam logic [15:0] START_PERIOD = 16'd1000;

  localparam logic [2:0] SEG_ACC1  = 3'd0;
  localparam logic [2:0] SEG_ACC2  = 3'd1;
  localparam logic [2:0] SEG_CONST = 3'd2;
  localparam logic [2:0] SEG_BRK1  = 3'd3;
  localparam logic [2:0] SEG_BRK2  = 3'd4;
  localparam logic [2:0] SEG_FINAL = 3'd5;

  localparam logic [2:0] CFG_FINAL_MIN = 3'd0;
  localparam logic [2:0] CFG_CONST_MIN = 3'd1;
  localparam logic [2:0] CFG_OUTER_MAX = 3'd2;
  localparam logic [2:0] CFG_INNER_MAX = 3'd3;
  localparam logic [2:0] CFG_ACC1_DLT  = 3'd4;
  localparam logic [2:0] CFG_ACC2_DLT  = 3'd5;
  localparam logic [2:0] CFG_BRK1_DLT  = 3'd6;
  localparam logic [2:0] CFG_BRK2_DLT  = 3'd7;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_BUILD1,
    CMD_BUILD2,
    CMD_BUILD3,
    CMD_BUILD4,
    CMD_BUILD5,
    CMD_LOAD,
    CMD_TICK,
    CMD_ADVANCE,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic move_active;
    logic phase;
    logic last_step;
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic       found;
    logic [2:0] idx;
  } seg_pick_t;

  // first non-empty segment at or after index from
  function automatic seg_pick_t find_segment(input logic [SEG_COUNT-1:0] mask,
                                             input logic [2:0] from);
    seg_pick_t pick;
    pick.found = 1'b0;
    pick.idx   = SEG_FINAL;
    for (int i = 0; i < SEG_COUNT; i++) begin
      if (!pick.found && (3'(i) >= from) && mask[i]) begin
        pick.found = 1'b1;
        pick.idx   = 3'(i);
      end
    end
    return pick;
  endfunction

endpackage

// File: src/sspg_ctrl.sv
// sequencing state machine of the stepper segment profile generator
module sspg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                op,
  input  sspg_pkg::dp_status_t status,
  output logic                in_stall,
  output sspg_pkg::cmd_t      cmd
);
  import sspg_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_BUILD1  = 10'b00_0000_0010,
    S_BUILD2  = 10'b00_0000_0100,
    S_BUILD3  = 10'b00_0000_1000,
    S_BUILD4  = 10'b00_0001_0000,
    S_BUILD5  = 10'b00_0010_0000,
    S_LOAD    = 10'b00_0100_0000,
    S_TICK    = 10'b00_1000_0000,
    S_ADVANCE = 10'b01_0000_0000,
    S_EMIT    = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_CAPTURE;
          state_next = op ? S_TICK : S_BUILD1;
        end
      end
      S_BUILD1: begin
        cmd        = CMD_BUILD1;
        state_next = S_BUILD2;
      end
      S_BUILD2: begin
        cmd        = CMD_BUILD2;
        state_next = S_BUILD3;
      end
      S_BUILD3: begin
        cmd        = CMD_BUILD3;
        state_next = S_BUILD4;
      end
      S_BUILD4: begin
        cmd        = CMD_BUILD4;
        state_next = S_BUILD5;
      end
      S_BUILD5: begin
        cmd        = CMD_BUILD5;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd        = CMD_LOAD;
        state_next = S_EMIT;
      end
      S_TICK: begin
        cmd = CMD_TICK;
        // falling edge of the last step of a segment needs a segment change
        if (status.move_active && status.phase && status.last_step) begin
          state_next = S_ADVANCE;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_ADVANCE: begin
        cmd        = CMD_ADVANCE;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd        = CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: src/sspg_dp.sv
// datapath: config registers, profile build, step counting and result register
module sspg_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  sspg_pkg::cmd_t       cmd,
  input  logic [15:0]          distance,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 out_stall,
  output sspg_pkg::dp_status_t status,
  output logic                 out_valid,
  output logic                 step_level,
  output logic [15:0]          period,
  output logic [2:0]           segment,
  output logic                 running,
  output logic                 done_res
);
  import sspg_pkg::*;

  logic [15:0] final_min, const_min, outer_max, inner_max;
  logic [15:0] acc1_dlt, acc2_dlt, brk1_dlt, brk2_dlt;

  logic [15:0] segs [SEG_COUNT];
  logic [2:0]  active_seg;
  logic [15:0] steps_left;
  logic [15:0] period_value;
  logic        pulse_phase;
  logic        move_active;
  logic        done;

  // profile build scratch
  logic [15:0] move_len;
  logic        short_move;
  logic [16:0] rem;
  logic [15:0] outer, inner;
  seg_pick_t   pick;

  logic [SEG_COUNT-1:0] seg_mask;
  seg_pick_t            first_pick, after_pick;
  logic [2:0]           rd_idx;
  logic [15:0]          rd_steps;
  logic [16:0]          limit_sum;
  logic [15:0]          delta;
  logic signed [17:0]   period_sum;
  logic [15:0]          period_sat;
  logic [16:0]          const_len;

  always_comb begin
    for (int i = 0; i < SEG_COUNT; i++) begin
      seg_mask[i] = (segs[i] != 16'd0);
    end
  end

  assign first_pick = find_segment(seg_mask, SEG_ACC1);
  assign after_pick = find_segment(seg_mask, active_seg + 3'd1);
  assign rd_idx     = (cmd == CMD_LOAD) ? first_pick.idx : pick.idx;
  assign rd_steps   = segs[rd_idx];
  assign limit_sum  = {1'b0, final_min} + {1'b0, const_min};
  assign const_len  = {1'b0, const_min} + rem - {inner, 1'b0};

  always_comb begin
    unique case (pick.idx)
      SEG_ACC1: delta = acc1_dlt;
      SEG_ACC2: delta = acc2_dlt;
      SEG_BRK1: delta = brk1_dlt;
      SEG_BRK2: delta = brk2_dlt;
      default:  delta = 16'd0;
    endcase
  end

  always_comb begin
    period_sum = $signed({2'b00, period_value}) + $signed({{2{delta[15]}}, delta});
    if (period_sum < 18'sd1) begin
      period_sat = 16'd1;
    end else if (period_sum > 18'sd65535) begin
      period_sat = 16'hFFFF;
    end else begin
      period_sat = period_sum[15:0];
    end
  end

  assign status.move_active = move_active;
  assign status.phase       = pulse_phase;
  assign status.last_step   = (steps_left <= 16'd1);
  assign status.out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      final_min <= '0;
      const_min <= '0;
      outer_max <= '0;
      inner_max <= '0;
      acc1_dlt  <= '0;
      acc2_dlt  <= '0;
      brk1_dlt  <= '0;
      brk2_dlt  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FINAL_MIN: final_min <= cfg_data;
        CFG_CONST_MIN: const_min <= cfg_data;
        CFG_OUTER_MAX: outer_max <= cfg_data;
        CFG_INNER_MAX: inner_max <= cfg_data;
        CFG_ACC1_DLT:  acc1_dlt  <= cfg_data;
        CFG_ACC2_DLT:  acc2_dlt  <= cfg_data;
        CFG_BRK1_DLT:  brk1_dlt  <= cfg_data;
        CFG_BRK2_DLT:  brk2_dlt  <= cfg_data;
        default: ;
      endcase
    end
  end

  // scratch registers, no reset
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_CAPTURE: move_len <= distance;
      CMD_BUILD1: begin
        short_move <= ({1'b0, move_len} <= limit_sum);
        rem        <= {1'b0, move_len} - limit_sum;
      end
      CMD_BUILD2: outer <= (rem[16:1] > outer_max) ? outer_max : rem[16:1];
      CMD_BUILD3: rem   <= rem - {outer, 1'b0};
      CMD_BUILD4: inner <= (rem[16:1] > inner_max) ? inner_max : rem[16:1];
      CMD_TICK:   pick  <= after_pick;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SEG_COUNT; i++) begin
        segs[i] <= '0;
      end
      active_seg   <= '0;
      steps_left   <= '0;
      period_value <= '0;
      pulse_phase  <= 1'b0;
      move_active  <= 1'b0;
      done         <= 1'b0;
    end else begin
      unique case (cmd)
        CMD_BUILD5: begin
          if (short_move) begin
            for (int i = 0; i < SEG_COUNT; i++) begin
              segs[i] <= '0;
            end
            segs[SEG_CONST] <= move_len;
          end else begin
            segs[SEG_ACC1]  <= outer;
            segs[SEG_BRK2]  <= outer;
            segs[SEG_ACC2]  <= inner;
            segs[SEG_BRK1]  <= inner;
            segs[SEG_FINAL] <= final_min;
            segs[SEG_CONST] <= const_len[15:0];
          end
        end
        CMD_LOAD: begin
          period_value <= START_PERIOD;
          if (first_pick.found) begin
            active_seg  <= first_pick.idx;
            steps_left  <= rd_steps;
            move_active <= 1'b1;
            done        <= 1'b0;
          end else begin
            active_seg  <= SEG_FINAL;
            steps_left  <= '0;
            move_active <= 1'b0;
            done        <= 1'b1;
          end
        end
        CMD_TICK: begin
          done <= 1'b0;
          if (move_active) begin
            pulse_phase <= ~pulse_phase;
            // falling edge completes a step
            if (pulse_phase && (steps_left != 16'd0)) begin
              steps_left <= steps_left - 16'd1;
            end
          end
        end
        CMD_ADVANCE: begin
          if (pick.found) begin
            period_value <= period_sat;
            active_seg   <= pick.idx;
            steps_left   <= rd_steps;
          end else begin
            move_active <= 1'b0;
            done        <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_EMIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_EMIT) begin
      step_level <= pulse_phase;
      period     <= period_value;
      segment    <= active_seg;
      running    <= move_active;
      done_res   <= done;
    end
  end

endmodule

// File: src/stepper_segment_profile_generator_top.sv
// top level of the stepper segment profile generator
//
// input channel (in_valid / in_stall): op 0 starts a move of distance steps, op 1 is a
// half-period timer tick. every request gives exactly one result on the output channel
// (out_valid / out_stall): step level, period, active segment, running and done flags.
// a start runs from acceptance to the result register in steps: five steps build the
// six segment lengths, one loads the first non-empty segment, one writes the result.
// a tick needs an advance step when it ends a segment and the next segment and the
// saturated period are picked. the sequencer handles one request at a time, so
// in_stall is high from acceptance until the result is registered.
// the result sits in an output register: the next request is taken while it waits,
// and a stalled receiver holds back only the following result.
// config writes (cfg_valid / cfg_ready, cfg_index 0..7, cfg_data) are always ready and
// are meant to happen only while the block is idle.
// synchronous reset clears the config registers, the segment table and the motion state,
// and empties the output register.
module stepper_segment_profile_generator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [15:0] distance,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        step_level,
  output logic [15:0] period,
  output logic [2:0]  segment,
  output logic        running,
  output logic        done_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sspg_pkg::*;

  cmd_t       cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  sspg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  sspg_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .distance   (distance),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_stall  (out_stall),
    .status     (status),
    .out_valid  (out_valid),
    .step_level (step_level),
    .period     (period),
    .segment    (segment),
    .running    (running),
    .done_res   (done_res)
  );

endmodule
